FILE: hw/rtl/alignment_column_classifier_assert.svh
// Assertion macros shared by the RTL of the alignment column classifier.
// ACC_ASSERT_IMPLY checks a consequence in the same cycle as its trigger,
// ACC_ASSERT_NEXT checks it in the cycle after its trigger.
`ifndef ALIGNMENT_COLUMN_CLASSIFIER_ASSERT_SVH
`define ALIGNMENT_COLUMN_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

`define ACC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ACC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/acc_pkg.sv
`timescale 1ns / 1ps

package acc_pkg;

    localparam int LANES      = 8;
    localparam int COUNT_BITS = 24;
    localparam int SYM_W      = 8;
    localparam int CFG_W      = 4;
    localparam int LABEL_W    = 3;
    localparam int KIND_W     = 3;
    localparam int CAT_W      = 4;
    localparam int CATEGORIES = 10;
    localparam int NUC_KINDS  = 4;

    localparam logic [CFG_W-1:0] CFG_LANES_RESET = CFG_W'(8);

    // Byte values that stand for the four nucleotides, in rank order.
    localparam logic [SYM_W-1:0] BYTE_NUC_1 = SYM_W'(66);
    localparam logic [SYM_W-1:0] BYTE_NUC_2 = SYM_W'(68);
    localparam logic [SYM_W-1:0] BYTE_NUC_3 = SYM_W'(72);
    localparam logic [SYM_W-1:0] BYTE_NUC_4 = SYM_W'(85);

    localparam int IN_TDATA_W  = LANES * SYM_W;
    localparam int OUT_BITS    = LANES * LABEL_W + 1 + KIND_W + CAT_W + COUNT_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        NUC_MISSING,
        NUC_1,
        NUC_2,
        NUC_3,
        NUC_4
    } t_nuc;

    typedef logic [NUC_KINDS:0]      t_seen;
    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [CAT_W-1:0]        t_cat;

    typedef struct packed {
        logic [LANES-1:0][LABEL_W-1:0] labels;
        logic                          missing;
        logic [KIND_W-1:0]             kinds;
        t_cat                          category;
    } t_class;

endpackage

FILE: hw/rtl/acc_lane.sv
`timescale 1ns / 1ps

module acc_lane (
    input  logic [acc_pkg::SYM_W-1:0] i_symbol,
    input  logic                      i_active,
    output acc_pkg::t_nuc             o_code,
    output acc_pkg::t_seen            o_seen
);
    import acc_pkg::*;

    t_nuc w_decoded;

    always_comb begin
        case (i_symbol)
            BYTE_NUC_1: w_decoded = NUC_1;
            BYTE_NUC_2: w_decoded = NUC_2;
            BYTE_NUC_3: w_decoded = NUC_3;
            BYTE_NUC_4: w_decoded = NUC_4;
            default:    w_decoded = NUC_MISSING;
        endcase
    end

    // An unused lane reports nothing and carries the missing code, which ranks as 0.
    always_comb begin
        o_seen = '0;
        o_code = NUC_MISSING;
        if (i_active) begin
            o_code = w_decoded;
            o_seen[w_decoded] = 1'b1;
        end
    end

endmodule

FILE: hw/rtl/acc_merge.sv
`timescale 1ns / 1ps

module acc_merge (
    input  acc_pkg::t_nuc  i_code [acc_pkg::LANES],
    input  acc_pkg::t_seen i_seen [acc_pkg::LANES],
    output acc_pkg::t_class o_class
);
    import acc_pkg::*;

    t_seen              w_present;
    logic [KIND_W-1:0]  w_kinds;
    logic [LABEL_W-1:0] w_rank [NUC_KINDS+1];
    logic [LABEL_W-1:0] w_next;

    always_comb begin
        w_present = '0;
        for (int l = 0; l < LANES; l++) begin
            w_present = w_present | i_seen[l];
        end
    end

    // Present nucleotides are numbered in order, starting after the missing code
    // when that code is in use.
    always_comb begin
        w_kinds   = '0;
        w_next    = LABEL_W'(w_present[0]);
        w_rank[0] = '0;
        for (int n = 1; n <= NUC_KINDS; n++) begin
            w_rank[n] = w_next;
            if (w_present[n]) begin
                w_next  = w_next + LABEL_W'(1);
                w_kinds = w_kinds + KIND_W'(1);
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_class.labels[l] = w_rank[i_code[l]];
        end
        o_class.missing  = w_present[0];
        o_class.kinds    = w_kinds;
        o_class.category = CAT_W'(w_present[0]) + (CAT_W'(w_kinds) << 1);
    end

endmodule

FILE: hw/rtl/acc_count.sv
`timescale 1ns / 1ps

module acc_count (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_inc,
    input  logic            i_clear,
    input  acc_pkg::t_cat   i_category,
    output acc_pkg::t_count o_count
);
    import acc_pkg::*;

    t_count r_count [CATEGORIES];
    t_count w_cur;

    // A clear request makes this item the first of its category.
    always_comb begin
        w_cur   = i_clear ? '0 : r_count[i_category];
        o_count = (&w_cur) ? w_cur : w_cur + COUNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CATEGORIES; c++) begin
                r_count[c] <= '0;
            end
        end else if (i_inc) begin
            if (i_clear) begin
                for (int c = 0; c < CATEGORIES; c++) begin
                    r_count[c] <= '0;
                end
            end
            r_count[i_category] <= o_count;
        end
    end

endmodule

FILE: hw/rtl/alignment_column_classifier.sv
// Channel      | Direction | Payload
// s_axis       | in        | tdata: symbol_0 .. symbol_7; tuser: start_req
// m_axis       | out       | tdata: labels, missing_present, kinds, category, index
// cfg          | in        | lanes_in_use, written when i_cfg_we is high
//
// One item per cycle is sustained while the output is taken. A result is registered in the
// output register after its item has passed stage one, and leaves from there.
// The lane decode and merge fill stage one; the category counter is read, bumped and
// written back in the same cycle in which an item moves on to the output register.
// Reset is synchronous: it clears every category count and both stages, and sets
// lanes_in_use to 8. While a result waits at the output, stage one takes one more item
// and then the input stalls until the output is taken.
`timescale 1ns / 1ps
`include "alignment_column_classifier_assert.svh"

module alignment_column_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [acc_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // symbol_0 .. symbol_7, one byte each, lane 0 lowest
    input  logic [acc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // start_req
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // label_0 .. label_7, missing_present, nucleotide_kinds, category, index_in_category
    output logic [acc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import acc_pkg::*;

    logic [CFG_W-1:0] r_lanes_in_use;

    logic    w_active [LANES];
    t_nuc    w_code   [LANES];
    t_seen   w_seen   [LANES];
    t_class  w_class;
    t_count  w_count;

    logic    r_s1_valid, n_s1_valid;
    t_class  r_s1_class;
    logic    r_s1_start;
    logic    r_out_valid, n_out_valid;
    t_class  r_out_class;
    t_count  r_out_count;

    logic    w_s_accept;
    logic    w_s1_move;
    logic    w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes_in_use <= CFG_LANES_RESET;
        end else if (i_cfg_we) begin
            r_lanes_in_use <= i_cfg_wdata;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_active[l] = int'(r_lanes_in_use) > l;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        acc_lane u_lane (
            .i_symbol (i_s_axis_tdata[g*SYM_W +: SYM_W]),
            .i_active (w_active[g]),
            .o_code   (w_code[g]),
            .o_seen   (w_seen[g])
        );
    end

    acc_merge u_merge (
        .i_code  (w_code),
        .i_seen  (w_seen),
        .o_class (w_class)
    );

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_s1_move       = r_s1_valid && w_out_free;
    assign o_s_axis_tready = !r_s1_valid || w_s1_move;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (w_out_free) begin
            n_out_valid = r_s1_valid;
        end
        if (o_s_axis_tready) begin
            n_s1_valid = i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_s1_class <= w_class;
            r_s1_start <= i_s_axis_tuser;
        end
        if (w_s1_move) begin
            r_out_class <= r_s1_class;
            r_out_count <= w_count;
        end
    end

    acc_count u_count (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_inc      (w_s1_move),
        .i_clear    (r_s1_start),
        .i_category (r_s1_class.category),
        .o_count    (w_count)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_count, r_out_class.category,
                                           r_out_class.kinds, r_out_class.missing,
                                           r_out_class.labels});

    `ACC_ASSERT_IMPLY(a_count_nonzero, i_clk, i_rst_n, r_out_valid, r_out_count != '0)
    `ACC_ASSERT_NEXT(a_start_counts_one, i_clk, i_rst_n, w_s1_move && r_s1_start, r_out_count == COUNT_BITS'(1))
    `ACC_ASSERT_NEXT(a_move_fills_out, i_clk, i_rst_n, w_s1_move, r_out_valid)
    `ACC_ASSERT_IMPLY(a_kinds_range, i_clk, i_rst_n, r_out_valid, int'(r_out_class.kinds) <= NUC_KINDS)

endmodule
